>>> hw/rtl/wehs_pkg.sv
package wehs_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int NUM_TYPES   = 16;
  localparam int TICK_W      = 32;
  localparam int TYPE_W      = 4;
  localparam int MASK_W      = 16;
  localparam int WIN_W       = 16;
  localparam int SUM_W       = 22;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1200;

  localparam logic CMD_LOG   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              command;
    logic              log_select;
    logic [TICK_W-1:0] now_tick;
    logic [TYPE_W-1:0] event_type;
    logic              success;
    logic [MASK_W-1:0] type_mask;
  } in_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] success_sum;
    logic [SUM_W-1:0] failure_sum;
  } out_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [TYPE_W-1:0] etype;
    logic              ok;
  } entry_t;

  typedef struct packed {
    logic log_write;
    logic load_query;
    logic issue_rd;
    logic eval;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic left_zero;
    logic stop;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/windowed_event_history_scorer.sv
// log request: written to the selected log on acceptance, produces no result; next request taken the cycle after
// query request: walks the selected log from its newest entry until one precedes the window start
//   or all entries (at most ENTRIES) are read; input stalls until the result is loaded; an empty log skips the walk;
//   the walk reads one log memory entry per cycle through a registered read port
// a finished result waits in the output register while new log requests are taken
// synchronous active-low reset clears heads, fill counts, control and window (1200);
//   log memory contents are not cleared
module windowed_event_history_scorer #(
  parameter int ENTRIES = wehs_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wehs_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wehs_pkg::out_req_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wehs_pkg::WIN_W-1:0]  cfg_data
);
  import wehs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  wehs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_data.command),
    .status     (status),
    .cmd        (cmd)
  );

  wehs_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

`ifndef SYNTHESIS
  a_log_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.command == CMD_LOG) && !out_valid) |=> !out_valid)
    else $error("log request produced a result");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.command == CMD_QUERY)) |=> in_stall)
    else $error("input not held off during query");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.log_write, cmd.load_query, cmd.out_load, cmd.eval}))
    else $error("conflicting datapath commands");
`endif

endmodule

>>> hw/rtl/wehs_ctrl.sv
module wehs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  wehs_pkg::dp_status_t  status,
  output wehs_pkg::ctl_cmd_t    cmd
);
  import wehs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_WALK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOG) begin
            cmd.log_write = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            state_nxt      = status.fill_zero ? S_DONE : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.issue_rd = 1'b1;
        state_nxt    = S_WALK;
      end
      S_WALK: begin
        cmd.eval = 1'b1;
        if (status.stop || status.left_zero) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.issue_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/wehs_dp.sv
module wehs_dp #(
  parameter int ENTRIES = wehs_pkg::DEF_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wehs_pkg::in_req_t             in_data,
  input  logic                          cfg_we,
  input  logic [wehs_pkg::WIN_W-1:0]    cfg_data,
  input  wehs_pkg::ctl_cmd_t            cmd,
  output wehs_pkg::dp_status_t          status,
  output wehs_pkg::out_req_t            out_data,
  output logic                          out_valid,
  input  logic                          out_stall
);
  import wehs_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int MD = 2 ** (IW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(ENTRIES);

  entry_t               log_mem [MD];
  entry_t               rd_r;
  entry_t               wr_entry;

  logic [IW-1:0]        head_r   [2];
  logic [IW-1:0]        head_nxt [2];
  logic [FW-1:0]        fill_r   [2];
  logic [FW-1:0]        fill_nxt [2];
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic                 q_sel_r, q_sel_nxt;
  logic [TICK_W-1:0]    q_now_r, q_now_nxt;
  logic [TICK_W-1:0]    q_start_r, q_start_nxt;
  logic [MASK_W-1:0]    q_mask_r, q_mask_nxt;
  logic [IW-1:0]        rptr_r, rptr_nxt;
  logic [FW-1:0]        left_r, left_nxt;
  logic                 pend_s_r, pend_s_nxt;
  logic                 pend_f_r, pend_f_nxt;
  logic [WIN_W-1:0]     pend_add_r, pend_add_nxt;
  logic [SUM_W-1:0]     sum_s_r, sum_s_nxt;
  logic [SUM_W-1:0]     sum_f_r, sum_f_nxt;
  out_req_t             out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [IW-1:0]        sel_head;
  logic [TICK_W:0]      diff;
  logic                 in_win;
  logic                 type_ok;
  logic [WIN_W-1:0]     add_val;
  logic [SUM_W:0]       acc_s;
  logic [SUM_W:0]       acc_f;

  assign sel_head = head_r[in_data.log_select];

  assign wr_entry.tick  = in_data.now_tick;
  assign wr_entry.etype = in_data.event_type;
  assign wr_entry.ok    = in_data.success;

  // entry evaluation
  assign diff    = {1'b0, q_now_r} - {1'b0, rd_r.tick};
  assign in_win  = !(rd_r.tick < q_start_r);
  assign type_ok = (int'(rd_r.etype) < NUM_TYPES) && q_mask_r[rd_r.etype];

  always_comb begin
    if (diff[TICK_W]) begin
      add_val = win_r;
    end else if (diff[TICK_W-1:WIN_W] != '0) begin
      add_val = '0;
    end else if (diff[WIN_W-1:0] >= win_r) begin
      add_val = '0;
    end else begin
      add_val = win_r - diff[WIN_W-1:0];
    end
  end

  assign acc_s = {1'b0, sum_s_r} + (SUM_W + 1)'(pend_add_r);
  assign acc_f = {1'b0, sum_f_r} + (SUM_W + 1)'(pend_add_r);

  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    win_nxt       = cfg_we ? cfg_data : win_r;
    q_sel_nxt     = q_sel_r;
    q_now_nxt     = q_now_r;
    q_start_nxt   = q_start_r;
    q_mask_nxt    = q_mask_r;
    rptr_nxt      = rptr_r;
    left_nxt      = left_r;
    pend_s_nxt    = cmd.eval && in_win && type_ok && rd_r.ok;
    pend_f_nxt    = cmd.eval && in_win && type_ok && !rd_r.ok;
    pend_add_nxt  = add_val;
    sum_s_nxt     = sum_s_r;
    sum_f_nxt     = sum_f_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.log_write) begin
      head_nxt[in_data.log_select] = (sel_head == LAST_IDX) ? '0 : sel_head + 1'b1;
      if (fill_r[in_data.log_select] != FULL_CNT) begin
        fill_nxt[in_data.log_select] = fill_r[in_data.log_select] + 1'b1;
      end
    end

    if (cmd.load_query) begin
      q_sel_nxt   = in_data.log_select;
      q_now_nxt   = in_data.now_tick;
      q_mask_nxt  = in_data.type_mask;
      q_start_nxt = (in_data.now_tick > TICK_W'(win_r)) ?
                    in_data.now_tick - TICK_W'(win_r) : '0;
      rptr_nxt    = (sel_head == '0) ? LAST_IDX : sel_head - 1'b1;
      left_nxt    = fill_r[in_data.log_select];
      sum_s_nxt   = '0;
      sum_f_nxt   = '0;
    end else begin
      if (pend_s_r) begin
        sum_s_nxt = acc_s[SUM_W] ? '1 : acc_s[SUM_W-1:0];
      end
      if (pend_f_r) begin
        sum_f_nxt = acc_f[SUM_W] ? '1 : acc_f[SUM_W-1:0];
      end
    end

    if (cmd.issue_rd) begin
      rptr_nxt = (rptr_r == '0) ? LAST_IDX : rptr_r - 1'b1;
      left_nxt = left_r - 1'b1;
    end

    if (cmd.out_load) begin
      out_nxt.success_sum = sum_s_r;
      out_nxt.failure_sum = sum_f_r;
      out_valid_nxt       = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.log_write) begin
      log_mem[{in_data.log_select, sel_head}] <= wr_entry;
    end
    if (cmd.issue_rd) begin
      rd_r <= log_mem[{q_sel_r, rptr_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r[0]   <= '0;
      head_r[1]   <= '0;
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      win_r       <= WINDOW_RESET;
      pend_s_r    <= 1'b0;
      pend_f_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      win_r       <= win_nxt;
      pend_s_r    <= pend_s_nxt;
      pend_f_r    <= pend_f_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_sel_r    <= q_sel_nxt;
    q_now_r    <= q_now_nxt;
    q_start_r  <= q_start_nxt;
    q_mask_r   <= q_mask_nxt;
    rptr_r     <= rptr_nxt;
    left_r     <= left_nxt;
    pend_add_r <= pend_add_nxt;
    sum_s_r    <= sum_s_nxt;
    sum_f_r    <= sum_f_nxt;
    out_r      <= out_nxt;
  end

  assign status.fill_zero = (fill_r[in_data.log_select] == '0);
  assign status.left_zero = (left_r == '0);
  assign status.stop      = !in_win;
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> tb/wehs_score_checker.sv
module wehs_score_checker #(
  parameter int ENTRIES = wehs_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  wehs_pkg::in_req_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  wehs_pkg::out_req_t          out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [wehs_pkg::WIN_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import wehs_pkg::*;

  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  entry_t           hist_mem [2][ENTRIES];
  int               hist_head [2];
  int               hist_fill [2];
  logic [WIN_W-1:0] window;
  out_req_t         sums_due [$];

  function automatic out_req_t decayed_sums(input logic sel, input logic [TICK_W-1:0] now,
                                            input logic [MASK_W-1:0] mask);
    logic [TICK_W-1:0] w_start;
    logic [TICK_W-1:0] age;
    logic [TICK_W-1:0] add;
    logic [63:0]       s_acc;
    logic [63:0]       f_acc;
    int                idx;
    entry_t            e;
    out_req_t          r;
    s_acc = '0;
    f_acc = '0;
    w_start = (now > {16'd0, window}) ? now - {16'd0, window} : '0;
    for (int k = 0; k < hist_fill[sel]; k++) begin
      idx = (hist_head[sel] + ENTRIES - 1 - k) % ENTRIES;
      e = hist_mem[sel][idx];
      if (e.tick < w_start) break;
      age = (e.tick > now) ? '0 : now - e.tick;
      add = (age >= {16'd0, window}) ? '0 : {16'd0, window} - age;
      if (int'(e.etype) < NUM_TYPES && mask[e.etype]) begin
        if (e.ok) s_acc += add;
        else f_acc += add;
      end
    end
    r.success_sum = (s_acc > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : s_acc[SUM_W-1:0];
    r.failure_sum = (f_acc > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : f_acc[SUM_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_req_t exp_sums;
    entry_t   ent;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      hist_head[0] = 0;
      hist_head[1] = 0;
      hist_fill[0] = 0;
      hist_fill[1] = 0;
      window = WINDOW_RESET;
      sums_due.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          $error("result with no request waiting: success_sum %0d failure_sum %0d",
                 out_data.success_sum, out_data.failure_sum);
          errs = errs + 1;
        end else begin
          exp_sums = sums_due.pop_front();
          if (out_data.success_sum !== exp_sums.success_sum) begin
            $error("success_sum expected %0d actual %0d",
                   exp_sums.success_sum, out_data.success_sum);
            errs = errs + 1;
          end
          if (out_data.failure_sum !== exp_sums.failure_sum) begin
            $error("failure_sum expected %0d actual %0d",
                   exp_sums.failure_sum, out_data.failure_sum);
            errs = errs + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == CMD_QUERY) begin
          sums_due.insert(sums_due.size(), decayed_sums(in_data.log_select, in_data.now_tick,
                                                        in_data.type_mask));
        end else begin
          ent.tick = in_data.now_tick;
          ent.etype = in_data.event_type;
          ent.ok = in_data.success;
          hist_mem[in_data.log_select][hist_head[in_data.log_select]] = ent;
          hist_head[in_data.log_select] = (hist_head[in_data.log_select] + 1) % ENTRIES;
          if (hist_fill[in_data.log_select] < ENTRIES)
            hist_fill[in_data.log_select] = hist_fill[in_data.log_select] + 1;
        end
      end
      if (cfg_valid && cfg_ready) window = cfg_data;
      fail_count <= fail_count + errs;
    end
    pending <= sums_due.size();
  end

endmodule

>>> tb/windowed_event_history_scorer_tb.sv
module windowed_event_history_scorer_tb;
  import wehs_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int LIMIT   = 400000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_req_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_req_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIN_W-1:0] cfg_data  = '0;

  int               fail_count;
  int               pending;
  int               cyc = 0;
  int               send_idle = 0;
  int               recv_idle = 0;
  int               step_max = 8;
  logic [TICK_W-1:0] game_tick = '0;
  logic [WIN_W-1:0] win_val;

  windowed_event_history_scorer #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  wehs_score_checker #(.ENTRIES(ENTRIES)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  initial begin
    wait (cyc >= LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_req_t log_req(input logic sel, input logic [TICK_W-1:0] tick,
                                      input logic [TYPE_W-1:0] etype, input logic ok);
    in_req_t r;
    r = '0;
    r.command = CMD_LOG;
    r.log_select = sel;
    r.now_tick = tick;
    r.event_type = etype;
    r.success = ok;
    r.type_mask = MASK_W'($urandom());
    return r;
  endfunction

  function automatic in_req_t query_req(input logic sel, input logic [TICK_W-1:0] now,
                                        input logic [MASK_W-1:0] mask);
    in_req_t r;
    r = '0;
    r.command = CMD_QUERY;
    r.log_select = sel;
    r.now_tick = now;
    r.event_type = TYPE_W'($urandom());
    r.success = 1'($urandom());
    r.type_mask = mask;
    return r;
  endfunction

  // mostly a running game clock, logs stamped now, queries near now
  function automatic in_req_t random_req();
    in_req_t r;
    int      pick;
    r = '0;
    r.log_select = 1'($urandom_range(0, 1));
    r.event_type = TYPE_W'($urandom_range(0, 15));
    r.success = 1'($urandom_range(0, 1));
    r.type_mask = ($urandom_range(0, 9) < 6) ? 16'hFFFF : MASK_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.command = ($urandom_range(0, 3) == 0) ? CMD_LOG : CMD_QUERY;
      r.now_tick = $urandom();
    end else if (pick < 72) begin
      r.command = CMD_LOG;
      r.now_tick = game_tick;
      game_tick = game_tick + TICK_W'($urandom_range(0, step_max));
    end else begin
      r.command = CMD_QUERY;
      if ($urandom_range(0, 7) == 0)
        r.now_tick = game_tick - TICK_W'($urandom_range(0, step_max));
      else
        r.now_tick = game_tick + TICK_W'($urandom_range(0, step_max));
    end
    return r;
  endfunction

  task automatic drive_req(input in_req_t req);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 37;
    recv_idle = 67;
    // empty log, then boundary ages at the reset window
    drive_req(query_req(1'b0, 32'd0, 16'hFFFF));
    drive_req(log_req(1'b0, 32'd100, 4'd0, 1'b1));
    drive_req(log_req(1'b0, 32'd1000, 4'd15, 1'b0));
    drive_req(log_req(1'b0, 32'd1300, 4'd5, 1'b1));
    drive_req(query_req(1'b0, 32'd1300, 16'hFFFF));
    drive_req(query_req(1'b0, 32'd1300, 16'h0020));
    drive_req(query_req(1'b0, 32'd1301, 16'hFFFF));
    drive_req(query_req(1'b0, 32'd50, 16'hFFFF));
    drive_req(query_req(1'b0, 32'd1300, 16'h0000));
    // order log at the top of the tick range
    drive_req(log_req(1'b1, 32'hFFFF_FFFF, 4'd3, 1'b1));
    drive_req(log_req(1'b1, 32'hFFFF_FFF0, 4'd3, 1'b0));
    drive_req(query_req(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    drive_req(query_req(1'b1, 32'hFFFF_FFFF, 16'h0008));
    drive_req(query_req(1'b1, 32'd0, 16'hFFFF));
    drive_req(log_req(1'b0, 32'd0, 4'd7, 1'b0));
    drive_req(query_req(1'b0, 32'd0, 16'h0080));
    drive_req(query_req(1'b1, 32'hFFFF_FFF8, 16'hFFF7));

    for (int seg = 0; seg < 9; seg++) begin
      case (seg / 3)
        0: begin
          send_idle = 37;
          recv_idle = 67;
        end
        1: begin
          send_idle = 67;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (seg)
        0: win_val = 16'd1;
        1: win_val = 16'hFFFF;
        2: win_val = 16'd0;
        3: win_val = WINDOW_RESET;
        5: win_val = WIN_W'($urandom_range(1, 400));
        6: win_val = 16'hFFFF;
        7: win_val = 16'd1;
        default: win_val = WIN_W'($urandom_range(1, 65535));
      endcase
      write_window(win_val);
      step_max = ($urandom_range(0, 3) == 0) ? 3 : int'(win_val) / 16 + 2;
      game_tick = $urandom();
      for (int n = 0; n < 56; n++) begin
        drive_req(random_req());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wehs_pkg.sv
hw/rtl/wehs_ctrl.sv
hw/rtl/wehs_dp.sv
hw/rtl/windowed_event_history_scorer.sv
tb/wehs_score_checker.sv
tb/windowed_event_history_scorer_tb.sv
